// File: hw/rtl/retransmit_window_table_macros.svh
// retransmit_window_table_macros.svh
// assertion macros used by the checker file of the window table
// expects clk and arst_n in the scope that uses them
`ifndef RETRANSMIT_WINDOW_TABLE_MACROS_SVH
`define RETRANSMIT_WINDOW_TABLE_MACROS_SVH

// same-cycle implication, off during reset
`define RWT_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("window table check failed");

// next-cycle implication, off during reset
`define RWT_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("window table check failed");

`endif

// File: hw/rtl/rwt_pkg.sv
// rwt_pkg.sv
// shared types, codes and defaults of the retransmit window table
// no dependencies
`default_nettype none

package rwt_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int FIELD_W = 16;

	// configuration register
	localparam logic REG_STALE_LIMIT = 1'b0;
	localparam logic [FIELD_W-1:0] STALE_LIMIT_RESET = 16'd1000;

	// item modes
	localparam logic [2:0] MODE_ADD_AUTO  = 3'd0;
	localparam logic [2:0] MODE_ADD_GIVEN = 3'd1;
	localparam logic [2:0] MODE_REMOVE    = 3'd2;
	localparam logic [2:0] MODE_EXPIRE    = 3'd3;
	localparam logic [2:0] MODE_COUNT     = 3'd4;

	// result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_MISS  = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;
	localparam logic [1:0] STAT_COUNT = 2'd3;

	// one stored window
	typedef struct packed {
		logic [FIELD_W-1:0] id;
		logic [FIELD_W-1:0] length;
		logic [FIELD_W-1:0] stamp;
	} rwt_entry_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIX,
		ST_RD,
		ST_XEMIT,
		ST_EMIT
	} rwt_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/rwt_slot_mem.sv
// rwt_slot_mem.sv
// slot storage: one write port, one registered read port
// depends on rwt_pkg for the entry type
`default_nettype none

module rwt_slot_mem #(
	parameter int DEPTH = rwt_pkg::TABLE_DEPTH_DEF,
	localparam int IDX_W = $clog2(DEPTH)
) (
	input  wire logic                clk,
	input  wire logic                wr_en,
	input  wire logic [IDX_W-1:0]    wr_addr,
	input  wire rwt_pkg::rwt_entry_t wr_data,
	input  wire logic                rd_en,
	input  wire logic [IDX_W-1:0]    rd_addr,
	output rwt_pkg::rwt_entry_t      rd_data
);

	rwt_pkg::rwt_entry_t mem_q [DEPTH];
	rwt_pkg::rwt_entry_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// File: hw/rtl/retransmit_window_table.sv
// channel   signals                           moves
// item      item_valid / item_ready           mode, entry_id, entry_length, now_ms
// result    result_valid / result_ready       out_id, out_length, status, entry_count, last
// config    psel penable pwrite paddr pwdata  stale_limit at byte address 0
//
// add and count: the emit state follows the accept and loads the result when output is free.
// remove and expiry: a scan through the one read port, then the commit state and the emit
// state, which also waits for a free output; a remove hit ends the scan early, and an expiry
// with stale entries passes a read state and an emit state for each result instead.
// item_ready is high only when the sequencer is idle; a stalled result holds the emit state.
// reset clears control state only; slot storage is never read before it is written.
`default_nettype none

module retransmit_window_table #(
	parameter int TABLE_DEPTH = rwt_pkg::TABLE_DEPTH_DEF,
	localparam int IDX_W = $clog2(TABLE_DEPTH),
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// item channel
	input  wire logic                         item_valid,
	output logic                              item_ready,
	input  wire logic [2:0]                   mode,
	input  wire logic [rwt_pkg::FIELD_W-1:0]  entry_id,
	input  wire logic [rwt_pkg::FIELD_W-1:0]  entry_length,
	input  wire logic [rwt_pkg::FIELD_W-1:0]  now_ms,
	// result channel
	output logic                              result_valid,
	input  wire logic                         result_ready,
	output logic [rwt_pkg::FIELD_W-1:0]       out_id,
	output logic [rwt_pkg::FIELD_W-1:0]       out_length,
	output logic [1:0]                        status,
	output logic [CNT_W-1:0]                  entry_count,
	output logic                              last,
	// configuration
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [2:0]                   paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	rwt_pkg::rwt_state_t state_q, state_d;

	logic [rwt_pkg::FIELD_W-1:0] stale_limit_q;
	logic [2:0]                  mode_q;
	logic [rwt_pkg::FIELD_W-1:0] id_q;
	logic [rwt_pkg::FIELD_W-1:0] now_q;
	logic [rwt_pkg::FIELD_W-1:0] auto_q;
	logic [rwt_pkg::FIELD_W-1:0] res_id_q;
	logic [1:0]                  res_status_q;
	logic [CNT_W-1:0]            held_q;
	logic [CNT_W-1:0]            pos_q;
	logic [CNT_W-1:0]            nk_q;
	logic [CNT_W-1:0]            ns_q;
	logic [IDX_W-1:0]            tail_q;
	logic [IDX_W-1:0]            emit_pos_q;
	logic [IDX_W-1:0]            found_pos_q;
	logic [IDX_W-1:0]            found_slot_q;
	logic                        found_q;
	logic [IDX_W-1:0]            order_q  [TABLE_DEPTH];
	logic [IDX_W-1:0]            norder_q [TABLE_DEPTH];
	logic [IDX_W-1:0]            order_up [TABLE_DEPTH];

	// scan pipeline stage: read issued last cycle
	logic                        cmp_v_s1;
	logic [IDX_W-1:0]            cmp_pos_s1;
	logic [IDX_W-1:0]            cmp_slot_s1;

	// result register
	logic                        result_valid_q;
	logic [rwt_pkg::FIELD_W-1:0] out_id_q;
	logic [rwt_pkg::FIELD_W-1:0] out_length_q;
	logic [1:0]                  status_q;
	logic [CNT_W-1:0]            entry_count_q;
	logic                        last_q;

	// combinational control
	logic                        item_accept;
	logic                        out_free;
	logic                        is_add;
	logic                        is_scan_mode;
	logic                        full;
	logic                        issue;
	logic                        hit;
	logic                        stale;
	logic                        scan_done;
	logic                        last_x;
	logic [CNT_W-1:0]            held_m1;
	logic [rwt_pkg::FIELD_W-1:0] age;
	logic                        cfg_wr;

	// slot memory interface
	logic                        wr_en;
	logic [IDX_W-1:0]            wr_addr;
	rwt_pkg::rwt_entry_t         wr_data;
	logic                        rd_en;
	logic [IDX_W-1:0]            rd_addr;
	rwt_pkg::rwt_entry_t         slot_rd;

	rwt_slot_mem #(
		.DEPTH(TABLE_DEPTH)
	) u_slot_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(slot_rd)
	);

	// order list moved up by one position, for removal
	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_shift
		if (g < TABLE_DEPTH - 1) begin : g_mid
			assign order_up[g] = order_q[g+1];
		end else begin : g_end
			assign order_up[g] = order_q[g];
		end
	end

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == rwt_pkg::REG_STALE_LIMIT);

	always_comb begin
		if (paddr[2] == rwt_pkg::REG_STALE_LIMIT) begin
			prdata = {{(32 - rwt_pkg::FIELD_W){1'b0}}, stale_limit_q};
		end else begin
			prdata = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_limit_q <= rwt_pkg::STALE_LIMIT_RESET;
		end else if (cfg_wr) begin
			stale_limit_q <= pwdata[rwt_pkg::FIELD_W-1:0];
		end
	end

	// shared status terms
	assign item_ready   = (state_q == rwt_pkg::ST_IDLE);
	assign item_accept  = item_valid & item_ready;
	assign out_free     = ~result_valid_q | result_ready;
	assign is_add       = (mode == rwt_pkg::MODE_ADD_AUTO) || (mode == rwt_pkg::MODE_ADD_GIVEN);
	assign is_scan_mode = (mode == rwt_pkg::MODE_REMOVE) || (mode == rwt_pkg::MODE_EXPIRE);
	assign full         = (held_q == CNT_W'(TABLE_DEPTH));
	assign held_m1      = held_q - CNT_W'(1);
	assign age          = now_q - slot_rd.stamp;

	// sequencer outputs
	always_comb begin
		issue     = 1'b0;
		hit       = 1'b0;
		stale     = 1'b0;
		scan_done = 1'b0;
		last_x    = (emit_pos_q == held_m1[IDX_W-1:0]);
		wr_en     = 1'b0;
		wr_addr   = order_q[held_q[IDX_W-1:0]];
		wr_data.id     = (mode == rwt_pkg::MODE_ADD_AUTO) ? auto_q : entry_id;
		wr_data.length = entry_length;
		wr_data.stamp  = now_ms;
		rd_en     = 1'b0;
		rd_addr   = order_q[emit_pos_q];
		unique case (state_q)
			rwt_pkg::ST_IDLE: begin
				wr_en = item_accept & is_add & ~full;
			end
			rwt_pkg::ST_SCAN: begin
				issue     = (pos_q < held_q);
				hit       = cmp_v_s1 && (mode_q == rwt_pkg::MODE_REMOVE) && (slot_rd.id == id_q);
				stale     = age > stale_limit_q;
				scan_done = ~issue & ~cmp_v_s1;
				rd_en     = issue;
				rd_addr   = order_q[pos_q[IDX_W-1:0]];
			end
			rwt_pkg::ST_RD: begin
				rd_en = 1'b1;
			end
			rwt_pkg::ST_FIX, rwt_pkg::ST_XEMIT, rwt_pkg::ST_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rwt_pkg::ST_IDLE: begin
				if (item_accept) begin
					state_d = is_scan_mode ? rwt_pkg::ST_SCAN : rwt_pkg::ST_EMIT;
				end
			end
			rwt_pkg::ST_SCAN: begin
				if (hit || scan_done) begin
					state_d = rwt_pkg::ST_FIX;
				end
			end
			rwt_pkg::ST_FIX: begin
				if ((mode_q == rwt_pkg::MODE_EXPIRE) && (ns_q != '0)) begin
					state_d = rwt_pkg::ST_RD;
				end else begin
					state_d = rwt_pkg::ST_EMIT;
				end
			end
			rwt_pkg::ST_RD: begin
				state_d = rwt_pkg::ST_XEMIT;
			end
			rwt_pkg::ST_XEMIT: begin
				if (out_free) begin
					state_d = last_x ? rwt_pkg::ST_IDLE : rwt_pkg::ST_RD;
				end
			end
			rwt_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = rwt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rwt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rwt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// table control state and scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= '0;
			auto_q       <= '0;
			mode_q       <= rwt_pkg::MODE_COUNT;
			res_status_q <= rwt_pkg::STAT_OK;
			pos_q        <= '0;
			nk_q         <= '0;
			ns_q         <= '0;
			tail_q       <= '0;
			emit_pos_q   <= '0;
			found_q      <= 1'b0;
			cmp_v_s1     <= 1'b0;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				order_q[i] <= IDX_W'(i);
			end
		end else begin
			cmp_v_s1 <= issue;
			unique case (state_q)
				// accept: adds and counts finish here, scans are set up
				rwt_pkg::ST_IDLE: begin
					if (item_accept) begin
						mode_q  <= mode;
						pos_q   <= '0;
						nk_q    <= '0;
						ns_q    <= '0;
						tail_q  <= held_m1[IDX_W-1:0];
						found_q <= 1'b0;
						if (is_add) begin
							if (full) begin
								res_status_q <= rwt_pkg::STAT_FULL;
							end else begin
								res_status_q <= rwt_pkg::STAT_OK;
								held_q       <= held_q + CNT_W'(1);
								if (mode == rwt_pkg::MODE_ADD_AUTO) begin
									auto_q <= auto_q + 16'd1;
								end
							end
						end else if (is_scan_mode) begin
							res_status_q <= rwt_pkg::STAT_OK;
						end else begin
							res_status_q <= rwt_pkg::STAT_COUNT;
						end
					end
				end
				// walk the table in order, one read issued per cycle
				rwt_pkg::ST_SCAN: begin
					if (issue) begin
						pos_q <= pos_q + CNT_W'(1);
					end
					if (hit) begin
						found_q <= 1'b1;
					end
					if (cmp_v_s1 && (mode_q == rwt_pkg::MODE_EXPIRE)) begin
						if (stale) begin
							tail_q <= tail_q - IDX_W'(1);
							ns_q   <= ns_q + CNT_W'(1);
						end else begin
							nk_q <= nk_q + CNT_W'(1);
						end
					end
				end
				// commit the reordered list, or set the miss status when nothing changes
				rwt_pkg::ST_FIX: begin
					if (mode_q == rwt_pkg::MODE_REMOVE) begin
						if (found_q) begin
							held_q <= held_m1;
							for (int q = 0; q < TABLE_DEPTH; q++) begin
								if (CNT_W'(q) + CNT_W'(1) == held_q) begin
									order_q[q] <= found_slot_q;
								end else if ((IDX_W'(q) >= found_pos_q) &&
										(CNT_W'(q) + CNT_W'(1) < held_q)) begin
									order_q[q] <= order_up[q];
								end
							end
						end else begin
							res_status_q <= rwt_pkg::STAT_MISS;
						end
					end else if (ns_q == '0) begin
						res_status_q <= rwt_pkg::STAT_MISS;
					end else begin
						emit_pos_q <= nk_q[IDX_W-1:0];
						for (int q = 0; q < TABLE_DEPTH; q++) begin
							if (CNT_W'(q) < held_q) begin
								order_q[q] <= norder_q[q];
							end
						end
					end
				end
				// step through the stale tail
				rwt_pkg::ST_XEMIT: begin
					if (out_free && !last_x) begin
						emit_pos_q <= emit_pos_q + IDX_W'(1);
					end
				end
				rwt_pkg::ST_RD, rwt_pkg::ST_EMIT: begin
				end
				default: begin
				end
			endcase
		end
	end

	// item payload and scan data, no reset needed
	always_ff @(posedge clk) begin
		if (item_accept) begin
			id_q  <= entry_id;
			now_q <= now_ms;
			if (mode == rwt_pkg::MODE_ADD_AUTO) begin
				res_id_q <= full ? '0 : auto_q;
			end else if (mode == rwt_pkg::MODE_ADD_GIVEN) begin
				res_id_q <= full ? '0 : entry_id;
			end else if (mode == rwt_pkg::MODE_REMOVE) begin
				res_id_q <= entry_id;
			end else begin
				res_id_q <= '0;
			end
		end
		cmp_pos_s1  <= pos_q[IDX_W-1:0];
		cmp_slot_s1 <= rd_addr;
		if (hit) begin
			found_pos_q  <= cmp_pos_s1;
			found_slot_q <= cmp_slot_s1;
		end
		// kept slots fill from the head, stale slots from the tail
		if ((state_q == rwt_pkg::ST_SCAN) && cmp_v_s1 && (mode_q == rwt_pkg::MODE_EXPIRE)) begin
			if (stale) begin
				norder_q[tail_q] <= cmp_slot_s1;
			end else begin
				norder_q[nk_q[IDX_W-1:0]] <= cmp_slot_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if ((state_q == rwt_pkg::ST_EMIT || state_q == rwt_pkg::ST_XEMIT) && out_free) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == rwt_pkg::ST_EMIT) begin
				out_id_q      <= res_id_q;
				out_length_q  <= '0;
				status_q      <= res_status_q;
				entry_count_q <= held_q;
				last_q        <= 1'b1;
			end else if (state_q == rwt_pkg::ST_XEMIT) begin
				out_id_q      <= slot_rd.id;
				out_length_q  <= slot_rd.length;
				status_q      <= rwt_pkg::STAT_OK;
				entry_count_q <= held_q;
				last_q        <= last_x;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign out_id       = out_id_q;
	assign out_length   = out_length_q;
	assign status       = status_q;
	assign entry_count  = entry_count_q;
	assign last         = last_q;

endmodule

`default_nettype wire

// File: hw/rtl/rwt_checker.sv
// rwt_checker.sv
// port-level checks of the retransmit window table, bound to the top level
// depends on rwt_pkg and retransmit_window_table_macros.svh
`default_nettype none

`include "retransmit_window_table_macros.svh"

module rwt_checker #(
	parameter int TABLE_DEPTH = rwt_pkg::TABLE_DEPTH_DEF,
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        item_valid,
	input wire logic                        item_ready,
	input wire logic                        result_valid,
	input wire logic                        result_ready,
	input wire logic [rwt_pkg::FIELD_W-1:0] out_id,
	input wire logic [1:0]                  status,
	input wire logic [CNT_W-1:0]            entry_count,
	input wire logic                        last
);

	// a stalled result holds
	`RWT_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(out_id) && $stable(last))

	// no new item while an expiry burst is still going out
	`RWT_ASSERT_IMP(a_busy_in_burst, result_valid && !last, !item_ready)

	// one item at a time
	`RWT_ASSERT_NXT(a_busy_after_accept, item_valid && item_ready, !item_ready)

	// count never passes the table size
	`RWT_ASSERT_IMP(a_count_range, result_valid, entry_count <= CNT_W'(TABLE_DEPTH))

	// a full report only with a full table
	`RWT_ASSERT_IMP(a_full_count, result_valid && (status == rwt_pkg::STAT_FULL), entry_count == CNT_W'(TABLE_DEPTH))

endmodule

bind retransmit_window_table rwt_checker #(
	.TABLE_DEPTH(TABLE_DEPTH)
) u_rwt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_ready  (item_ready),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.out_id      (out_id),
	.status      (status),
	.entry_count (entry_count),
	.last        (last)
);

`default_nettype wire
